// ===== rtl/vpha_pkg.sv =====
// vpha_pkg: types and constants shared by the hole allocator
// holds the item structs, the policy codes and the reset table of hole sizes
// no dependencies
`default_nettype none

package vpha_pkg;

  // fit policy held in the configuration register
  typedef enum logic [1:0] {
    FIRST_FIT = 2'd0,
    BEST_FIT  = 2'd1,
    WORST_FIT = 2'd2,
    NEXT_FIT  = 2'd3
  } policy_t;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  localparam int SIZE_W = 16;
  localparam int HOLE_W = 3;

  // input item
  typedef struct packed {
    logic              req_type;
    logic [HOLE_W-1:0] hole_number;
    logic [SIZE_W-1:0] size_value;
  } req_t;

  // result item
  typedef struct packed {
    logic              granted;
    logic [HOLE_W-1:0] chosen_hole;
    logic [SIZE_W-1:0] size_before;
    logic [SIZE_W-1:0] size_after;
  } rsp_t;

  // hole sizes after reset, holes past the table start empty
  localparam int INIT_COUNT = 8;
  localparam logic [SIZE_W-1:0] INIT_SIZES [INIT_COUNT] =
    '{16'd10, 16'd4, 16'd20, 16'd18, 16'd7, 16'd9, 16'd12, 16'd15};

  function automatic logic [SIZE_W-1:0] init_size(input int k);
    logic [SIZE_W-1:0] s;
    s = '0;
    if (k < INIT_COUNT) begin
      s = INIT_SIZES[k[2:0]];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vpha_cell.sv =====
// vpha_cell: one hole size in the rotating ring of cells
// takes its neighbour's size on a shift, or a direct write at the end of an item
// depends on vpha_pkg
`default_nettype none

module vpha_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [vpha_pkg::SIZE_W-1:0] init_size,
  input  wire logic                      shift,
  input  wire logic [vpha_pkg::SIZE_W-1:0] shift_in,
  input  wire logic                      wr_en,
  input  wire logic [vpha_pkg::SIZE_W-1:0] wr_data,
  output logic      [vpha_pkg::SIZE_W-1:0] size
);
  import vpha_pkg::*;

  // size register: reset value, direct write, or rotate from neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= init_size;
    end else if (wr_en) begin
      size <= wr_data;
    end else if (shift) begin
      size <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vpha_scan.sv =====
// vpha_scan: fit selector watching the head of the ring, one hole a cycle
// keeps the running choice for first, best and worst fit and the wrapped next-fit choice
// depends on vpha_pkg
`default_nettype none

module vpha_scan #(
  parameter int IDX_W = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        step,
  input  wire vpha_pkg::policy_t           policy,
  input  wire logic [vpha_pkg::SIZE_W-1:0] head_size,
  input  wire logic [IDX_W-1:0]            head_idx,
  input  wire logic [vpha_pkg::SIZE_W-1:0] req_size,
  input  wire logic [IDX_W-1:0]            next_start,
  output logic                             found,
  output logic      [IDX_W-1:0]            pick_idx,
  output logic      [vpha_pkg::SIZE_W-1:0] pick_size
);
  import vpha_pkg::*;

  logic              any_found;
  logic [IDX_W-1:0]  any_idx;
  logic [SIZE_W-1:0] any_size;
  logic              hi_found;
  logic [IDX_W-1:0]  hi_idx;
  logic [SIZE_W-1:0] hi_size;
  logic              fits;
  logic              any_take;
  logic              hi_take;

  // does the head hole fit and does it beat the running choice
  always_comb begin
    fits = head_size >= req_size;
    any_take = 1'b0;
    if (!any_found) begin
      any_take = fits;
    end else begin
      unique case (policy)
        BEST_FIT:  any_take = fits && (head_size < any_size);
        WORST_FIT: any_take = fits && (head_size > any_size);
        FIRST_FIT: any_take = 1'b0;
        NEXT_FIT:  any_take = 1'b0;
        default:   any_take = 1'b0;
      endcase
    end
    // first fitting hole at or after the next-fit pointer
    hi_take = fits && !hi_found && (head_idx >= next_start);
  end

  // running choices
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      any_found <= 1'b0;
      hi_found  <= 1'b0;
    end else if (step) begin
      if (any_take) begin
        any_found <= 1'b1;
        any_idx   <= head_idx;
        any_size  <= head_size;
      end
      if (hi_take) begin
        hi_found <= 1'b1;
        hi_idx   <= head_idx;
        hi_size  <= head_size;
      end
    end
  end

  // next fit prefers the hole after the pointer, else wraps to the lowest
  always_comb begin
    if (policy == NEXT_FIT && hi_found) begin
      found     = 1'b1;
      pick_idx  = hi_idx;
      pick_size = hi_size;
    end else begin
      found     = any_found;
      pick_idx  = any_idx;
      pick_size = any_size;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/variable_partition_hole_allocator_top.sv =====
// variable_partition_hole_allocator_top: hole allocator over a ring of size cells
// instantiates vpha_cell and vpha_scan, depends on vpha_pkg
//
// Usage
//   An item is taken on a clock edge with start high and busy low. It either
//   loads one hole's size or allocates a request under the policy register.
//   The policy is written through cfg_valid/cfg_ready/cfg_data; the user must
//   write it only while idle (the block does not enforce it); cfg_ready is always high.
//   Every item gives one result on rsp, marked by done for a single cycle;
//   the receiver cannot stall it and must take it in that cycle.
// Timing
//   An allocate rotates the ring of HOLE_COUNT cells once past the fit
//   selector, one hole a cycle, then writes the chosen hole in ST_FINISH;
//   done is registered from ST_FINISH. A load skips the rotation and goes
//   from ST_IDLE straight to ST_FINISH. busy drops in the cycle done is high,
//   so a new item may start there.
// Reset
//   rst is synchronous; hole sizes return to 10,4,20,18,7,9,12,15 (further
//   holes 0), the next-fit pointer to 0 and the policy to first fit.
`default_nettype none

module variable_partition_hole_allocator_top #(
  parameter int HOLE_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire vpha_pkg::req_t    req,
  output logic                   done,
  output vpha_pkg::rsp_t         rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire vpha_pkg::policy_t cfg_data
);
  import vpha_pkg::*;

  localparam int IDX_W = $clog2(HOLE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOLE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  cnt;
  req_t              req_q;
  policy_t           policy;
  logic [IDX_W-1:0]  next_start;
  rsp_t              rsp_next;

  logic              accept;
  logic              scanning;
  logic              finishing;
  logic [SIZE_W-1:0] sizes [HOLE_COUNT];
  logic              found;
  logic [IDX_W-1:0]  pick_idx;
  logic [SIZE_W-1:0] pick_size;
  logic              is_load;
  logic              hole_ok;
  logic              wr_active;
  logic [IDX_W-1:0]  wr_idx;
  logic [SIZE_W-1:0] wr_data;
  logic [SIZE_W-1:0] alloc_after;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign scanning  = (state == ST_SCAN);
  assign finishing = (state == ST_FINISH);
  assign cfg_ready = 1'b1;

  // policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= FIRST_FIT;
    end else if (cfg_valid && cfg_ready) begin
      policy <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_LOAD) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (scanning) begin
        cnt <= (cnt == LAST_IDX) ? '0 : cnt + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // ring of cells, cell 0 is the head seen by the selector
  for (genvar k = 0; k < HOLE_COUNT; k++) begin : g_cell
    vpha_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .init_size (init_size(k)),
      .shift     (scanning),
      .shift_in  (sizes[(k + 1) % HOLE_COUNT]),
      .wr_en     (finishing && wr_active && (wr_idx == IDX_W'(k))),
      .wr_data   (wr_data),
      .size      (sizes[k])
    );
  end

  vpha_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .step       (scanning),
    .policy     (policy),
    .head_size  (sizes[0]),
    .head_idx   (cnt),
    .req_size   (req_q.size_value),
    .next_start (next_start),
    .found      (found),
    .pick_idx   (pick_idx),
    .pick_size  (pick_size)
  );

  // update of the chosen or loaded hole and the result
  always_comb begin
    is_load     = (req_q.req_type == REQ_LOAD);
    hole_ok     = (int'(req_q.hole_number) < HOLE_COUNT);
    alloc_after = pick_size - req_q.size_value;
    wr_active   = is_load ? hole_ok : found;
    wr_idx      = is_load ? IDX_W'(req_q.hole_number) : pick_idx;
    wr_data     = is_load ? req_q.size_value : alloc_after;
    rsp_next    = '0;
    if (is_load) begin
      rsp_next.chosen_hole = req_q.hole_number;
      rsp_next.size_after  = hole_ok ? req_q.size_value : '0;
    end else if (found) begin
      rsp_next.granted     = 1'b1;
      rsp_next.chosen_hole = HOLE_W'(pick_idx);
      rsp_next.size_before = pick_size;
      rsp_next.size_after  = alloc_after;
    end
  end

  // next-fit pointer moves past a hole granted under next fit
  always_ff @(posedge clk) begin
    if (rst) begin
      next_start <= '0;
    end else if (finishing && !is_load && found && policy == NEXT_FIT) begin
      next_start <= (pick_idx == LAST_IDX) ? '0 : pick_idx + 1'b1;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finishing;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
